@@ rtl/irss_pkg.sv @@
// ----------------------------------------------------------------------------
// irss_pkg: shared types and constants for the ID record store.
// Holds the default sizes, the status codes and the item passed between the
// front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
package irss_pkg;

  localparam int unsigned MemBytesDef = 256;
  localparam int unsigned MaxIdLenDef = 16;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_GET    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_FOUND    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_BADIDX   = 3'd4,
    ST_BYTE     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    OP_STAGE  = 2'd0,
    OP_ADD    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_GET    = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] id_byte;
    logic [7:0] record_index;
  } item_t;

endpackage
`default_nettype wire

@@ rtl/irss_front.sv @@
// ----------------------------------------------------------------------------
// irss_front: input word intake and classification.
// Decodes each word into a back-end operation and holds it in a two-entry
// queue; unused commands are taken and dropped.
// ----------------------------------------------------------------------------
`default_nettype none
module irss_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [1:0]     cmd_i,
  input  wire logic [7:0]     id_byte_i,
  input  wire logic           id_last_i,
  input  wire logic [7:0]     record_index_i,
  output logic                item_valid_o,
  input  wire logic           item_ready_i,
  output irss_pkg::item_t     item_o
);
  import irss_pkg::*;

  item_t      fifo_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  item_t      item_new;
  logic       push, pop;

  always_comb begin
    item_new.id_byte      = id_byte_i;
    item_new.record_index = record_index_i;
    unique case (cmd_i)
      CMD_ADD:    item_new.op = id_last_i ? OP_ADD : OP_STAGE;
      CMD_SEARCH: item_new.op = id_last_i ? OP_SEARCH : OP_STAGE;
      default:    item_new.op = OP_GET;
    endcase
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = fifo_q[rptr_q];
  assign push         = in_valid_i && in_ready_o && (cmd_i != CMD_NONE);
  assign pop          = item_valid_o && item_ready_i;

  always_comb begin
    wptr_d = wptr_q ^ push;
    rptr_d = rptr_q ^ pop;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= item_new;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("push into full queue");
  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wptr_q != rptr_q)) else $error("pointers disagree");

endmodule
`default_nettype wire

@@ rtl/irss_back.sv @@
// ----------------------------------------------------------------------------
// irss_back: record engine.
// Stages ID bytes, appends records, walks the record memory for search and
// get, and drives the registered result port.
// ----------------------------------------------------------------------------
`default_nettype none
module irss_back #(
  parameter int unsigned MemBytes = irss_pkg::MemBytesDef,
  parameter int unsigned MaxIdLen = irss_pkg::MaxIdLenDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            item_valid_i,
  output logic                 item_ready_o,
  input  wire irss_pkg::item_t item_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [2:0]           status_o,
  output logic [7:0]           found_index_o,
  output logic [7:0]           out_byte_o,
  output logic [4:0]           out_length_o,
  output logic                 out_last_o
);
  import irss_pkg::*;

  localparam int unsigned AW = $clog2(MemBytes);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned LW = $clog2(MaxIdLen + 1);
  localparam int unsigned IW = $clog2(MaxIdLen);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_LEN, S_ADD_BYTE, S_SRCH_HDR, S_SRCH_LEN, S_SRCH_RD,
    S_SRCH_CMP, S_GET_HDR, S_GET_LEN, S_GET_RD, S_GET_OUT, S_EMIT
  } state_e;

  state_e        state_q, state_d;
  logic [LW-1:0] slen_q, slen_d, len_q, len_d, j_q, j_d, nlen;
  logic [7:0]    cnt_q, cnt_d, i_q, i_d, ridx_q, ridx_d, res_fi_q, res_fi_d;
  logic [PW-1:0] fp_q, fp_d, a_q, a_d;
  status_e       res_st_q, res_st_d;
  logic [7:0]    staged_q [MaxIdLen];
  logic          stg_we;
  logic [7:0]    mem [MemBytes];
  logic [7:0]    rdata_q;
  logic          we, re;
  logic [AW-1:0] maddr;
  logic [7:0]    wdata;
  logic [PW:0]   need;
  logic          space, load, o_last;
  status_e       o_st;
  logic [7:0]    o_fi, o_byte;
  logic [4:0]    o_len;
  logic          out_valid_q;
  logic [2:0]    status_q;
  logic [7:0]    found_index_q, out_byte_q;
  logic [4:0]    out_length_q;
  logic          out_last_q;

  assign space        = !out_valid_q || out_ready_i;
  assign item_ready_o = (state_q == S_IDLE);
  assign nlen         = (slen_q < LW'(MaxIdLen)) ? slen_q + LW'(1) : slen_q;
  assign need         = {1'b0, fp_q} + (PW + 1)'(1) + (PW + 1)'(nlen);

  always_comb begin
    state_d  = state_q;
    slen_d   = slen_q;
    len_d    = len_q;
    j_d      = j_q;
    cnt_d    = cnt_q;
    i_d      = i_q;
    ridx_d   = ridx_q;
    fp_d     = fp_q;
    a_d      = a_q;
    res_st_d = res_st_q;
    res_fi_d = res_fi_q;
    stg_we   = 1'b0;
    we       = 1'b0;
    re       = 1'b0;
    maddr    = '0;
    wdata    = '0;
    load     = 1'b0;
    o_st     = res_st_q;
    o_fi     = res_fi_q;
    o_byte   = '0;
    o_len    = '0;
    o_last   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          unique case (item_i.op)
            OP_STAGE: begin
              stg_we = (slen_q < LW'(MaxIdLen));
              slen_d = nlen;
            end
            OP_ADD: begin
              stg_we = (slen_q < LW'(MaxIdLen));
              slen_d = '0;
              len_d  = nlen;
              if (cnt_q == 8'hFF || need > (PW + 1)'(MemBytes)) begin
                res_st_d = ST_FULL;
                res_fi_d = cnt_q;
                state_d  = S_EMIT;
              end else begin
                state_d = S_ADD_LEN;
              end
            end
            OP_SEARCH: begin
              stg_we  = (slen_q < LW'(MaxIdLen));
              slen_d  = '0;
              len_d   = nlen;
              a_d     = '0;
              i_d     = '0;
              state_d = S_SRCH_HDR;
            end
            default: begin
              if (item_i.record_index >= cnt_q) begin
                res_st_d = ST_BADIDX;
                res_fi_d = '0;
                state_d  = S_EMIT;
              end else begin
                ridx_d  = item_i.record_index;
                a_d     = '0;
                i_d     = '0;
                state_d = S_GET_HDR;
              end
            end
          endcase
        end
      end
      S_ADD_LEN: begin
        we      = 1'b1;
        maddr   = fp_q[AW-1:0];
        wdata   = 8'(len_q);
        j_d     = '0;
        state_d = S_ADD_BYTE;
      end
      S_ADD_BYTE: begin
        if (j_q == len_q) begin
          fp_d     = fp_q + PW'(1) + PW'(len_q);
          cnt_d    = cnt_q + 8'd1;
          res_st_d = ST_ADDED;
          res_fi_d = cnt_q + 8'd1;
          state_d  = S_EMIT;
        end else begin
          we    = 1'b1;
          maddr = AW'(fp_q + PW'(1) + PW'(j_q));
          wdata = staged_q[j_q[IW-1:0]];
          j_d   = j_q + LW'(1);
        end
      end
      S_SRCH_HDR: begin
        if (i_q == cnt_q) begin
          res_st_d = ST_NOTFOUND;
          res_fi_d = '0;
          state_d  = S_EMIT;
        end else begin
          re      = 1'b1;
          maddr   = a_q[AW-1:0];
          state_d = S_SRCH_LEN;
        end
      end
      S_SRCH_LEN: begin
        if (rdata_q == 8'(len_q)) begin
          j_d     = '0;
          state_d = S_SRCH_RD;
        end else begin
          a_d     = a_q + PW'(rdata_q) + PW'(1);
          i_d     = i_q + 8'd1;
          state_d = S_SRCH_HDR;
        end
      end
      S_SRCH_RD: begin
        if (j_q == len_q) begin
          res_st_d = ST_FOUND;
          res_fi_d = i_q;
          state_d  = S_EMIT;
        end else begin
          re      = 1'b1;
          maddr   = AW'(a_q + PW'(1) + PW'(j_q));
          state_d = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (rdata_q == staged_q[j_q[IW-1:0]]) begin
          j_d     = j_q + LW'(1);
          state_d = S_SRCH_RD;
        end else begin
          a_d     = a_q + PW'(1) + PW'(len_q);
          i_d     = i_q + 8'd1;
          state_d = S_SRCH_HDR;
        end
      end
      S_GET_HDR: begin
        re      = 1'b1;
        maddr   = a_q[AW-1:0];
        state_d = S_GET_LEN;
      end
      S_GET_LEN: begin
        if (i_q == ridx_q) begin
          len_d   = LW'(rdata_q);
          j_d     = '0;
          state_d = S_GET_RD;
        end else begin
          a_d     = a_q + PW'(rdata_q) + PW'(1);
          i_d     = i_q + 8'd1;
          state_d = S_GET_HDR;
        end
      end
      S_GET_RD: begin
        re      = 1'b1;
        maddr   = AW'(a_q + PW'(1) + PW'(j_q));
        state_d = S_GET_OUT;
      end
      S_GET_OUT: begin
        o_st   = ST_BYTE;
        o_fi   = ridx_q;
        o_byte = rdata_q;
        o_len  = 5'(len_q);
        o_last = (j_q + LW'(1) == len_q);
        if (space) begin
          load = 1'b1;
          if (o_last) begin
            state_d = S_IDLE;
          end else begin
            j_d     = j_q + LW'(1);
            state_d = S_GET_RD;
          end
        end
      end
      default: begin
        if (space) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slen_q      <= '0;
      cnt_q       <= '0;
      fp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      slen_q  <= slen_d;
      cnt_q   <= cnt_d;
      fp_q    <= fp_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q    <= len_d;
    j_q      <= j_d;
    i_q      <= i_d;
    ridx_q   <= ridx_d;
    a_q      <= a_d;
    res_st_q <= res_st_d;
    res_fi_q <= res_fi_d;
    if (stg_we) begin
      staged_q[slen_q[IW-1:0]] <= item_i.id_byte;
    end
    if (load) begin
      status_q      <= o_st;
      found_index_q <= o_fi;
      out_byte_q    <= o_byte;
      out_length_q  <= o_len;
      out_last_q    <= o_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[maddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[maddr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_index_o = found_index_q;
  assign out_byte_o    = out_byte_q;
  assign out_length_o  = out_length_q;
  assign out_last_o    = out_last_q;

  a_slen_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slen_q <= LW'(MaxIdLen)) else $error("staged length overflow");
  a_fp_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, fp_q} <= (PW + 1)'(MemBytes)) else $error("free pointer overflow");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH_HDR || state_q == S_GET_HDR) |-> (a_q <= fp_q))
    else $error("record walk past free pointer");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> space) else $error("result overwritten");

endmodule
`default_nettype wire

@@ rtl/id_record_store_search.sv @@
// ----------------------------------------------------------------------------
// id_record_store_search: store of card IDs as length-prefixed byte records.
// Add writes the length byte, then each ID byte; search reads each record's
// length and compares its bytes when the length matches; get skips records
// and returns one byte per result word; all share the single memory port.
// Throughput: one word per cycle through the intake queue while not full, one
// command at a time in the record engine.
// Reset clears the record count, free pointer and staging; memory is not swept.
// ----------------------------------------------------------------------------
`default_nettype none
module id_record_store_search #(
  parameter int unsigned MemBytes = irss_pkg::MemBytesDef,
  parameter int unsigned MaxIdLen = irss_pkg::MaxIdLenDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // cmd [1:0], id_byte [9:2], record_index [17:10]
  input  wire logic [23:0] s_axis_tdata_i,
  // id_last
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // status [2:0], found_index [10:3], out_byte [18:11], out_length [23:19]
  output logic [23:0]      m_axis_tdata_o,
  // out_last
  output logic             m_axis_tlast_o
);
  import irss_pkg::*;

  item_t      item;
  logic       item_valid, item_ready;
  logic [2:0] status;
  logic [7:0] found_index, out_byte;
  logic [4:0] out_length;

  irss_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .cmd_i          (s_axis_tdata_i[1:0]),
    .id_byte_i      (s_axis_tdata_i[9:2]),
    .id_last_i      (s_axis_tlast_i),
    .record_index_i (s_axis_tdata_i[17:10]),
    .item_valid_o   (item_valid),
    .item_ready_i   (item_ready),
    .item_o         (item)
  );

  irss_back #(
    .MemBytes (MemBytes),
    .MaxIdLen (MaxIdLen)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_ready_o  (item_ready),
    .item_i        (item),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .status_o      (status),
    .found_index_o (found_index),
    .out_byte_o    (out_byte),
    .out_length_o  (out_length),
    .out_last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {out_length, out_byte, found_index, status};

endmodule
`default_nettype wire
